### hw/rtl/hsfc_pkg.sv
// Shared types, constants and stage records for the half/single converter.
package hsfc_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic {
    REQ_WIDEN  = 1'b0,
    REQ_NARROW = 1'b1
  } req_t;

  typedef struct packed {
    logic        sign;
    logic [7:0]  ebits;
    logic [22:0] fr;
    req_t        req;
    logic [4:0]  hex;
    logic [9:0]  hfr;
    logic [3:0]  lz;
    logic [4:0]  sh;
  } dec_t;

  typedef struct packed {
    req_t        req;
    logic        sign;
    logic [31:0] wres;
    logic [15:0] nres;
    logic        sub;
    logic [10:0] q;
    logic [23:0] rem;
    logic [23:0] half;
  } mid_t;

endpackage

### hw/rtl/hsfc_decode.sv
// Decode stage: split the operand, count half leading zeros and form the subnormal shift.
module hsfc_decode
  import hsfc_pkg::*;
(
  input  logic             req_type,
  input  logic [DataW-1:0] operand_bits,
  output dec_t             dec
);

  always_comb begin
    dec.req = req_t'(req_type);
    dec.sign = (req_type == REQ_NARROW) ? operand_bits[31] : operand_bits[15];
    dec.ebits = operand_bits[30:23];
    dec.fr = operand_bits[22:0];
    dec.hex = operand_bits[14:10];
    dec.hfr = operand_bits[9:0];
    dec.lz = 4'd0;
    for (int i = 9; i >= 0; i--) begin
      if (operand_bits[i] && dec.lz == 4'd0) begin
        dec.lz = 4'(10 - i);
      end
    end
    dec.sh = 5'(9'd126 - 9'(operand_bits[30:23]));
  end

endmodule

### hw/rtl/hsfc_convert.sv
// Conversion stages: alignment with rounding add, then final rounding and result select.
module hsfc_align
  import hsfc_pkg::*;
(
  input  dec_t dec,
  output mid_t mid
);

  logic [9:0]  nfr;
  logic [23:0] rnd;
  logic [23:0] mant;
  logic [23:0] mask;

  always_comb begin
    mid.req = dec.req;
    mid.sign = dec.sign;
    nfr = 10'(dec.hfr << dec.lz);
    if (dec.hex == 5'd0) begin
      if (dec.hfr == 10'd0) begin
        mid.wres = {dec.sign, 31'd0};
      end else begin
        mid.wres = {dec.sign, 8'(8'd113 - 8'(dec.lz)), nfr, 13'd0};
      end
    end else if (dec.hex == 5'h1f) begin
      mid.wres = {dec.sign, 8'hff, dec.hfr, 13'd0};
    end else begin
      mid.wres = {dec.sign, 8'(8'(dec.hex) + 8'd112), dec.hfr, 13'd0};
    end

    rnd = 24'({1'b0, dec.fr}) + 24'h000fff + 24'(dec.fr[13]);
    mant = {1'b1, dec.fr};
    mask = 24'((32'd1 << dec.sh) - 32'd1);
    mid.q = 11'(mant >> dec.sh);
    mid.rem = mant & mask;
    mid.half = 24'(32'd1 << (dec.sh - 5'd1));
    mid.sub = 1'b0;
    if (dec.ebits == 8'hff) begin
      mid.nres = {dec.sign, 5'h1f, (dec.fr != 23'd0) ? {1'b1, dec.fr[21:13]} : 10'd0};
    end else if (dec.ebits > 8'd142) begin
      mid.nres = {dec.sign, 15'h7c00};
    end else if (dec.ebits >= 8'd113) begin
      if (rnd[23]) begin
        if (dec.ebits == 8'd142) begin
          mid.nres = {dec.sign, 15'h7c00};
        end else begin
          mid.nres = {dec.sign, 5'(dec.ebits - 8'd111), 10'd0};
        end
      end else begin
        mid.nres = {dec.sign, 5'(dec.ebits - 8'd112), rnd[22:13]};
      end
    end else if (dec.ebits < 8'd102) begin
      mid.nres = {dec.sign, 15'd0};
    end else begin
      mid.nres = {dec.sign, 15'd0};
      mid.sub = 1'b1;
    end
  end

endmodule

module hsfc_convert
  import hsfc_pkg::*;
(
  input  mid_t             mid,
  output logic [DataW-1:0] result
);

  logic [10:0] qr;
  logic [15:0] nres;

  always_comb begin
    qr = mid.q;
    if (mid.rem > mid.half || (mid.rem == mid.half && mid.q[0])) begin
      qr = mid.q + 11'd1;
    end
    nres = mid.sub ? {mid.sign, 4'd0, qr} : mid.nres;
    result = (mid.req == REQ_NARROW) ? {16'd0, nres} : mid.wres;
  end

endmodule

### hw/rtl/half_single_float_converter.sv
// Top level: three-stage stallable pipeline of decode, alignment and rounding.
// Stage one splits the operand and counts leading zeros, stage two aligns
// and adds the rounding increment, stage three finishes rounding and picks
// the result. An item moves through the s0, s1 and s2 registers in turn and
// out_valid is driven from s2. One item is taken every cycle while the
// output side does not stall; out_stall holds a full stage only while every
// stage ahead is full too, so the input stalls only when all three are full.
module half_single_float_converter
  import hsfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_req_type,
  input  logic [DataW-1:0] in_operand_bits,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [DataW-1:0] out_result_bits
);

  logic             s0_v_r, s1_v_r, s2_v_r;
  dec_t             dec, s0_dec_r;
  mid_t             mid, s1_mid_r;
  logic [DataW-1:0] res, s2_res_r;
  logic             adv2, adv1, adv0;

  assign adv2 = !s2_v_r || !out_stall;
  assign adv1 = !s1_v_r || adv2;
  assign adv0 = !s0_v_r || adv1;
  assign in_stall = !adv0;

  hsfc_decode u_dec (.req_type(in_req_type), .operand_bits(in_operand_bits), .dec(dec));
  hsfc_align u_aln (.dec(s0_dec_r), .mid(mid));
  hsfc_convert u_cvt (.mid(s1_mid_r), .result(res));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (adv0) s0_v_r <= in_valid;
      if (adv1) s1_v_r <= s0_v_r;
      if (adv2) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0) s0_dec_r <= dec;
    if (adv1) s1_mid_r <= mid;
    if (adv2) s2_res_r <= res;
  end

  assign out_valid = s2_v_r;
  assign out_result_bits = s2_res_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_bits))
    else $error("result lost under stall");
  a_upper: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_mid_r.req == REQ_NARROW && adv2 |=> s2_res_r[31:16] == 16'd0)
    else $error("narrow result upper half not zero");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && adv2 |=> s2_v_r)
    else $error("item dropped between stages");

endmodule
